// ===== rtl/ppfa_pkg.sv =====
package ppfa_pkg;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REGION  = 2'd2;
    localparam logic [1:0] CMD_RESERVE = 2'd3;

    localparam logic [2:0] ST_ALLOC   = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_NOTFREE = 3'd2;
    localparam logic [2:0] ST_FREED   = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    localparam logic [31:0] REGION_AVAILABLE = 32'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  page;
        logic        common;
        logic [63:0] region_base;
        logic [63:0] region_length;
        logic [31:0] region_type;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] page_out;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       clr_step;
        logic       load_in;
        logic       pop;
        logic       free_rd;
        logic       free_wr;
        logic       alloc_rd_map;
        logic       alloc_wr;
        logic       region_sum;
        logic       region_load;
        logic       walk_step;
        logic       resv0;
        logic       resv1;
        logic       out_load;
        logic [2:0] out_status;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       count_zero;
        logic       page_oob;
        logic       map_bit;
        logic       region_ok;
        logic       walk_last;
        logic       clear_last;
        logic       out_busy;
    } dp_status_t;

endpackage

// ===== rtl/phys_page_frame_allocator.sv =====
// each item is taken in idle and decoded; alloc then pops the stack and reads the popped
// page's free bit, free reads the page's free bit, reserve clears the free bits of pages
// 0 and 1, a region checks its bounds and walks one page per cycle; empty alloc and
// out-of-range free skip to the result, which waits for a free output register; one item at a time
// reset: synchronous active-low aresetn, then a clearing pass over both bitmaps
// during which no input is taken
module phys_page_frame_allocator #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_SHIFT = 22
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ppfa_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ppfa_pkg::out_item_t m_data
);

    ppfa_pkg::ctrl_cmd_t  cmd;
    ppfa_pkg::dp_status_t st;

    ppfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ppfa_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .st      (st)
    );

endmodule

// ===== rtl/ppfa_datapath.sv =====
module ppfa_datapath #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_SHIFT = 22
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ppfa_pkg::in_item_t   s_data,
    output ppfa_pkg::out_item_t  m_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  ppfa_pkg::ctrl_cmd_t  cmd,
    output ppfa_pkg::dp_status_t st
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam int CW = PW + 1;

    logic [PW-1:0] stack_mem [NUM_PAGES];
    logic          free_mem  [NUM_PAGES];
    logic          common_mem[NUM_PAGES];

    ppfa_pkg::in_item_t  in_reg, in_next;
    ppfa_pkg::out_item_t out_reg, out_next;
    logic                m_valid_reg, m_valid_next;
    logic [64:0]         end_reg, end_next;
    logic [CW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       e_reg, e_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [PW-1:0]       clr_reg, clr_next;
    logic [PW-1:0]       stack_rd_reg;
    logic                fm_rd_reg;

    logic [PW+9:0] pg_ext;
    logic [PW+9:0] top_ext;
    logic [PW-1:0] page_idx;
    logic [63:0]   s_page;
    logic [63:0]   e_page;
    logic [CW-1:0] pop_cnt;
    logic          stack_full;
    logic          push_en;
    logic [PW-1:0] st_wd;
    logic          fm_we, fm_wd, fm_re;
    logic [PW-1:0] fm_wa, fm_ra;
    logic          cm_we;
    logic [PW-1:0] cm_wa;

    assign pg_ext   = {{PW{1'b0}}, in_reg.page};
    assign page_idx = pg_ext[PW-1:0];
    assign top_ext  = {10'b0, stack_rd_reg};

    assign s_page  = in_reg.region_base >> PAGE_SHIFT;
    assign e_page  = end_reg[63:0] >> PAGE_SHIFT;
    assign pop_cnt = count_reg - CW'(1);

    assign stack_full = (count_reg == CW'(NUM_PAGES));
    assign push_en    = (cmd.free_wr | cmd.walk_step) & ~stack_full;
    assign st_wd      = cmd.walk_step ? cur_reg[PW-1:0] : page_idx;

    always_comb begin
        fm_we = cmd.clr_step | cmd.resv0 | cmd.resv1 | cmd.free_wr | cmd.alloc_wr
              | cmd.walk_step;
        fm_wd = cmd.free_wr | cmd.walk_step;
        if (cmd.clr_step) begin
            fm_wa = clr_reg;
        end else if (cmd.resv0) begin
            fm_wa = PW'(0);
        end else if (cmd.resv1) begin
            fm_wa = PW'(1);
        end else if (cmd.free_wr) begin
            fm_wa = page_idx;
        end else if (cmd.walk_step) begin
            fm_wa = cur_reg[PW-1:0];
        end else begin
            fm_wa = stack_rd_reg;
        end
        fm_re = cmd.free_rd | cmd.alloc_rd_map;
        fm_ra = cmd.free_rd ? page_idx : stack_rd_reg;

        cm_we = cmd.clr_step | cmd.free_wr | (cmd.alloc_wr & in_reg.common);
        if (cmd.clr_step) begin
            cm_wa = clr_reg;
        end else if (cmd.free_wr) begin
            cm_wa = page_idx;
        end else begin
            cm_wa = stack_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fm_we) begin
            free_mem[fm_wa] <= fm_wd;
        end
        if (fm_re) begin
            fm_rd_reg <= free_mem[fm_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (cm_we) begin
            common_mem[cm_wa] <= cmd.alloc_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[count_reg[PW-1:0]] <= st_wd;
        end
        if (cmd.pop) begin
            stack_rd_reg <= stack_mem[pop_cnt[PW-1:0]];
        end
    end

    always_comb begin
        in_next  = cmd.load_in ? s_data : in_reg;
        end_next = cmd.region_sum
                 ? ({1'b0, in_reg.region_base} + {1'b0, in_reg.region_length})
                 : end_reg;

        cur_next = cur_reg;
        e_next   = e_reg;
        if (cmd.region_load) begin
            cur_next = s_page[CW-1:0];
            e_next   = e_page[CW-1:0];
        end else if (cmd.walk_step) begin
            cur_next = cur_reg + CW'(1);
        end

        clr_next = cmd.clr_step ? clr_reg + PW'(1) : clr_reg;

        count_next = count_reg;
        if (cmd.pop) begin
            count_next = pop_cnt;
        end else if (push_en) begin
            count_next = count_reg + CW'(1);
        end

        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            out_next.status   = cmd.out_status;
            out_next.page_out = (cmd.out_status == ppfa_pkg::ST_ALLOC) ? top_ext[9:0] : 10'd0;
            m_valid_next      = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        end_reg <= end_next;
        cur_reg <= cur_next;
        e_reg   <= e_next;
        out_reg <= out_next;
    end

    always_comb begin
        st.cmd        = in_reg.cmd;
        st.count_zero = (count_reg == '0);
        st.page_oob   = (32'(in_reg.page) >= 32'(NUM_PAGES));
        st.map_bit    = fm_rd_reg;
        // region must be of the available type, must not wrap, must end inside the pages and hold at least one page
        st.region_ok  = ~end_reg[64] && (e_page <= 64'(NUM_PAGES))
                      && (in_reg.region_type == ppfa_pkg::REGION_AVAILABLE)
                      && (s_page < e_page);
        st.walk_last  = ((cur_reg + CW'(1)) == e_reg);
        st.clear_last = (clr_reg == PW'(NUM_PAGES - 1));
        st.out_busy   = m_valid_reg & ~m_ready;
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(NUM_PAGES))
        else $error("stack count beyond page count");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> count_reg != '0)
        else $error("pop on empty stack");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten before transfer");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> (cur_reg < e_reg) && (e_reg <= CW'(NUM_PAGES)))
        else $error("region walk outside its pages");

endmodule

// ===== rtl/ppfa_ctrl.sv =====
module ppfa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ppfa_pkg::dp_status_t st,
    output ppfa_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_FREE_CHK,
        S_REGION_CHK,
        S_REGION_WALK,
        S_RESV1,
        S_RESP
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] res_reg, res_next;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.out_status = res_reg;
        s_ready    = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (st.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (st.cmd)
                    ppfa_pkg::CMD_ALLOC: begin
                        if (st.count_zero) begin
                            res_next   = ppfa_pkg::ST_EMPTY;
                            state_next = S_RESP;
                        end else begin
                            cmd.pop    = 1'b1;
                            state_next = S_ALLOC_RD;
                        end
                    end
                    ppfa_pkg::CMD_FREE: begin
                        if (st.page_oob) begin
                            res_next   = ppfa_pkg::ST_IGNORED;
                            state_next = S_RESP;
                        end else begin
                            cmd.free_rd = 1'b1;
                            state_next  = S_FREE_CHK;
                        end
                    end
                    ppfa_pkg::CMD_REGION: begin
                        cmd.region_sum = 1'b1;
                        state_next     = S_REGION_CHK;
                    end
                    default: begin
                        cmd.resv0  = 1'b1;
                        state_next = S_RESV1;
                    end
                endcase
            end
            S_ALLOC_RD: begin
                // popped index is in the stack read register, fetch its free bit
                cmd.alloc_rd_map = 1'b1;
                state_next       = S_ALLOC_CHK;
            end
            S_ALLOC_CHK: begin
                if (st.map_bit) begin
                    cmd.alloc_wr = 1'b1;
                    res_next     = ppfa_pkg::ST_ALLOC;
                end else begin
                    res_next     = ppfa_pkg::ST_NOTFREE;
                end
                state_next = S_RESP;
            end
            S_FREE_CHK: begin
                if (st.map_bit) begin
                    res_next    = ppfa_pkg::ST_IGNORED;
                end else begin
                    cmd.free_wr = 1'b1;
                    res_next    = ppfa_pkg::ST_FREED;
                end
                state_next = S_RESP;
            end
            S_REGION_CHK: begin
                if (st.region_ok) begin
                    cmd.region_load = 1'b1;
                    state_next      = S_REGION_WALK;
                end else begin
                    res_next   = ppfa_pkg::ST_DONE;
                    state_next = S_RESP;
                end
            end
            S_REGION_WALK: begin
                cmd.walk_step = 1'b1;
                if (st.walk_last) begin
                    res_next   = ppfa_pkg::ST_DONE;
                    state_next = S_RESP;
                end
            end
            S_RESV1: begin
                cmd.resv1  = 1'b1;
                res_next   = ppfa_pkg::ST_DONE;
                state_next = S_RESP;
            end
            S_RESP: begin
                // wait until the output register is free for the transfer
                if (!st.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            res_reg   <= ppfa_pkg::ST_DONE;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule
